FILE: hdl/lmsdb_pkg.sv
// ----------------------------------------------------------------------------
// lmsdb_pkg
// Shared types and constants for the LED matrix scan double buffer unit:
// request and register codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package lmsdb_pkg;

    localparam int unsigned MAX_MODULES = 32;
    localparam int unsigned HALF_BYTES  = MAX_MODULES * 8;
    localparam int unsigned OFF_W       = $clog2(HALF_BYTES);
    localparam int unsigned ADDR_W      = OFF_W + 1;
    localparam int unsigned CNT_W       = OFF_W + 1;

    // largest module row count that still fits, per column count 1..8
    localparam int unsigned ROW_CAP [8] = '{
        MAX_MODULES / 1, MAX_MODULES / 2, MAX_MODULES / 3, MAX_MODULES / 4,
        MAX_MODULES / 5, MAX_MODULES / 6, MAX_MODULES / 7, MAX_MODULES / 8
    };

    localparam logic [7:0] FILL_BLACK = 8'hFF;
    localparam logic [7:0] FILL_CLEAR = 8'h00;

    typedef enum logic [1:0] {
        REQ_PIXEL = 2'd0,
        REQ_FILL  = 2'd1,
        REQ_SWAP  = 2'd2,
        REQ_TICK  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_MODULE_COLUMNS = 2'd0,
        CFG_MODULE_ROWS    = 2'd1,
        CFG_DOUBLE_BUFFER  = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_PIX_WR,
        S_FILL,
        S_COPY,
        S_EMIT_RD,
        S_EMIT_DATA,
        S_EMIT_ROW
    } t_state;

    typedef struct packed {
        logic load_item;
        logic pix_read;
        logic pix_write;
        logic fill_start;
        logic fill_step;
        logic swap_req;
        logic tick_begin;
        logic copy_start;
        logic copy_step;
        logic emit_start;
        logic emit_data;
        logic emit_row;
    } t_dp_cmd;

    typedef struct packed {
        t_req req;
        logic pix_ok;
        logic copy_go;
        logic fill_done;
        logic copy_done;
        logic out_free;
        logic emit_last;
    } t_dp_sts;

endpackage

FILE: hdl/lmsdb_ctrl.sv
// ----------------------------------------------------------------------------
// lmsdb_ctrl
// Request sequencer: decodes each accepted request and steps the datapath
// through pixel read-modify-write, fill sweep, buffer copy and row burst.
// ----------------------------------------------------------------------------
module lmsdb_ctrl
    import lmsdb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.req)
                    REQ_PIXEL: begin
                        if (i_sts.pix_ok) begin
                            o_cmd.pix_read = 1'b1;
                            n_state        = S_PIX_WR;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                    REQ_FILL: begin
                        o_cmd.fill_start = 1'b1;
                        n_state          = S_FILL;
                    end
                    REQ_SWAP: begin
                        o_cmd.swap_req = 1'b1;
                        n_state        = S_IDLE;
                    end
                    REQ_TICK: begin
                        o_cmd.tick_begin = 1'b1;
                        if (i_sts.copy_go) begin
                            o_cmd.copy_start = 1'b1;
                            n_state          = S_COPY;
                        end else begin
                            o_cmd.emit_start = 1'b1;
                            n_state          = S_EMIT_RD;
                        end
                    end
                endcase
            end
            S_PIX_WR: begin
                o_cmd.pix_write = 1'b1;
                n_state         = S_IDLE;
            end
            S_FILL: begin
                if (i_sts.fill_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.fill_step = 1'b1;
                end
            end
            S_COPY: begin
                if (i_sts.copy_done) begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = S_EMIT_RD;
                end else begin
                    o_cmd.copy_step = 1'b1;
                end
            end
            S_EMIT_RD: begin
                // wait for the registered read
                n_state = S_EMIT_DATA;
            end
            S_EMIT_DATA: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_data = 1'b1;
                    n_state         = S_EMIT_ROW;
                end
            end
            S_EMIT_ROW: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_row = 1'b1;
                    n_state        = i_sts.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DISPATCH))
        else $error("accepted request not dispatched");

    a_pix_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PIX_WR) |-> ($past(r_state) == S_DISPATCH && $past(o_cmd.pix_read)))
        else $error("pixel write without preceding read");
`endif

endmodule

FILE: hdl/lmsdb_datapath.sv
// ----------------------------------------------------------------------------
// lmsdb_datapath
// Configuration and scan registers, panel geometry, the two-half frame
// memory with registered read, sweep counters and the output register.
// ----------------------------------------------------------------------------
module lmsdb_datapath
    import lmsdb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data,
    input  logic [1:0] i_req_type,
    input  logic [5:0] i_x,
    input  logic [4:0] i_y,
    input  logic       i_color,
    input  logic       i_copy_after_swap,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [7:0] o_spi_byte,
    output logic       o_frame_first,
    output logic       o_last
);

    logic [3:0]       r_cols_cfg;
    logic [2:0]       r_rows_cfg;
    logic             r_dbuf;
    logic             r_back_sel;
    logic             r_swap_pend;
    logic             r_copy_pend;
    logic [2:0]       r_scan_row;

    t_req             r_req;
    logic [5:0]       r_x;
    logic [4:0]       r_y;
    logic             r_color;
    logic             r_copy;

    logic [CNT_W-1:0] r_idx;
    logic             r_cp_wr;
    logic [OFF_W-1:0] r_widx;
    logic [7:0]       r_rd_data;

    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_first;
    logic             r_out_last;

    logic [7:0]       mem [2*HALF_BYTES];

    logic [3:0]       cols;
    logic [2:0]       rows_clamp;
    logic [2:0]       rows;
    logic [2:0]       cols_m1;
    logic [CNT_W-1:0] size;
    logic [2:0]       xm;
    logic [1:0]       ym;
    logic [1:0]       mr;
    logic [2:0]       mc;
    logic [4:0]       mod_idx;
    logic [7:0]       pix_off;
    logic [7:0]       bit_mask;
    logic [7:0]       pix_byte;
    logic             back_hi;
    logic             front_hi;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]       wr_data;
    logic             wr_en;
    logic [CNT_W-1:0] idx_next8;
    logic             emit_last;
    logic             out_free;
    logic             out_load;

    // clamp geometry to 1..8 columns and 1..4 rows, then to the module budget
    always_comb begin
        if (r_cols_cfg == 4'd0) begin
            cols = 4'd1;
        end else if (r_cols_cfg > 4'd8) begin
            cols = 4'd8;
        end else begin
            cols = r_cols_cfg;
        end
        if (r_rows_cfg == 3'd0) begin
            rows_clamp = 3'd1;
        end else if (r_rows_cfg > 3'd4) begin
            rows_clamp = 3'd4;
        end else begin
            rows_clamp = r_rows_cfg;
        end
        cols_m1 = 3'(cols - 4'd1);
        if (32'(rows_clamp) > ROW_CAP[cols_m1]) begin
            rows = 3'(ROW_CAP[cols_m1]);
        end else begin
            rows = rows_clamp;
        end
        size = CNT_W'({6'(cols) * 6'(rows), 3'b000});
    end

    // serpentine placement: first byte belongs to the last module in the chain
    always_comb begin
        xm       = r_x[5:3];
        ym       = r_y[4:3];
        mr       = 2'(rows - 3'd1 - {1'b0, ym});
        mc       = mr[0] ? xm : 3'(cols - 4'd1 - {1'b0, xm});
        mod_idx  = 5'(5'(mr) * 5'(cols) + 5'(mc));
        pix_off  = {mod_idx, r_y[2:0]};
        bit_mask = 8'd1 << r_x[2:0];
        pix_byte = r_color ? (r_rd_data | bit_mask) : (r_rd_data & ~bit_mask);
    end

    assign back_hi   = r_dbuf & r_back_sel;
    assign front_hi  = r_dbuf & ~r_back_sel;
    assign rd_addr   = i_cmd.pix_read ? {back_hi, pix_off} : {front_hi, r_idx[OFF_W-1:0]};
    assign idx_next8 = r_idx + CNT_W'(8);
    assign emit_last = idx_next8 >= size;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign out_load  = i_cmd.emit_data || i_cmd.emit_row;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {back_hi, r_widx};
        wr_data = r_rd_data;
        priority if (i_cmd.pix_write) begin
            wr_en   = 1'b1;
            wr_addr = {back_hi, pix_off};
            wr_data = pix_byte;
        end else if (i_cmd.fill_step && (r_idx < size)) begin
            wr_en   = 1'b1;
            wr_addr = {back_hi, r_idx[OFF_W-1:0]};
            wr_data = r_color ? FILL_CLEAR : FILL_BLACK;
        end else if (r_cp_wr) begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // request payload and sweep indexes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_req   <= t_req'(i_req_type);
            r_x     <= i_x;
            r_y     <= i_y;
            r_color <= i_color;
            r_copy  <= i_copy_after_swap;
        end
        r_widx <= r_idx[OFF_W-1:0];
        priority if (i_cmd.fill_start || i_cmd.copy_start) begin
            r_idx <= '0;
        end else if (i_cmd.emit_start) begin
            r_idx <= CNT_W'(r_scan_row);
        end else if ((i_cmd.fill_step || i_cmd.copy_step) && (r_idx < size)) begin
            r_idx <= r_idx + CNT_W'(1);
        end else if (i_cmd.emit_row) begin
            r_idx <= idx_next8;
        end
        if (out_load) begin
            r_out_byte  <= i_cmd.emit_data ? r_rd_data : (8'd1 << r_scan_row);
            r_out_first <= i_cmd.emit_data && (r_idx == CNT_W'(r_scan_row));
            r_out_last  <= i_cmd.emit_row && emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg  <= 4'd1;
            r_rows_cfg  <= 3'd1;
            r_dbuf      <= 1'b0;
            r_back_sel  <= 1'b0;
            r_swap_pend <= 1'b0;
            r_copy_pend <= 1'b0;
            r_scan_row  <= '0;
            r_cp_wr     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MODULE_COLUMNS: r_cols_cfg <= i_cfg_data;
                    CFG_MODULE_ROWS:    r_rows_cfg <= i_cfg_data[2:0];
                    CFG_DOUBLE_BUFFER:  r_dbuf     <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.swap_req && r_dbuf) begin
                r_swap_pend <= 1'b1;
                r_copy_pend <= r_copy;
            end
            if (i_cmd.tick_begin && r_swap_pend) begin
                r_back_sel  <= ~r_back_sel;
                r_swap_pend <= 1'b0;
                r_copy_pend <= 1'b0;
            end
            r_cp_wr <= i_cmd.copy_step && (r_idx < size);
            if (i_cmd.emit_row && emit_last) begin
                r_scan_row <= r_scan_row + 3'd1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.req       = r_req;
        o_sts.pix_ok    = ({1'b0, xm} < cols) && ({1'b0, ym} < rows);
        o_sts.copy_go   = r_swap_pend && r_copy_pend && r_dbuf;
        o_sts.fill_done = r_idx == size;
        o_sts.copy_done = (r_idx == size) && !r_cp_wr;
        o_sts.out_free  = out_free;
        o_sts.emit_last = emit_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_spi_byte    = r_out_byte;
    assign o_frame_first = r_out_first;
    assign o_last        = r_out_last;

`ifndef ASSERT_OFF
    a_copy_halves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_wr |-> (back_hi != front_hi))
        else $error("buffer copy within one half");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("output register overwritten while stalled");

    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_row && emit_last) |=> (r_scan_row == $past(r_scan_row) + 3'd1))
        else $error("scan row not advanced after burst");
`endif

endmodule

FILE: hdl/led_matrix_scan_double_buffer_unit.sv
// ----------------------------------------------------------------------------
// led_matrix_scan_double_buffer_unit
// Frame store and row-scan driver for a serpentine chain of 8x8 LED modules.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_stall    req_type, x, y, color, copy_after_swap
//   out      source     o_out_valid / i_out_stall  spi_byte, frame_first, last
//   cfg      sink       i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
// One request at a time. A pixel write is a read-modify-write; off the panel it is dropped.
// Fill: one memory write per cycle over the panel bytes.
// Refresh tick: one read and two output bytes per module, held by output stall,
// preceded by a copy of the panel bytes when a pending swap copies.
// Reset is synchronous; the frame memory is not cleared and holds garbage
// until a fill or pixel write. Output stall holds the burst in place.
// ----------------------------------------------------------------------------
module led_matrix_scan_double_buffer_unit
    import lmsdb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_req_type,
    input  logic [5:0] i_x,
    input  logic [4:0] i_y,
    input  logic       i_color,
    input  logic       i_copy_after_swap,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_spi_byte,
    output logic       o_frame_first,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    busy;

    assign o_in_stall  = busy;
    assign o_cfg_ready = 1'b1;

    lmsdb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    lmsdb_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_req_type),
        .i_x               (i_x),
        .i_y               (i_y),
        .i_color           (i_color),
        .i_copy_after_swap (i_copy_after_swap),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_spi_byte        (o_spi_byte),
        .o_frame_first     (o_frame_first),
        .o_last            (o_last)
    );

endmodule
